// ----- hw/rtl/cctr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctr_pkg: shared types and constants for the color code decoder
// Beat layouts of both channels, the palette entry layout, the work item that
// travels from the front to the back, and the fixed color codes.
// ----------------------------------------------------------------------------
package cctr_pkg;

    // Input beat: a lookup or a palette write
    typedef struct packed {
        logic               kind;
        logic signed [31:0] color_number;
        logic [7:0]         main_red;
        logic [7:0]         main_green;
        logic [7:0]         main_blue;
        logic [7:0]         main_alpha;
        logic [7:0]         dither_red;
        logic [7:0]         dither_green;
        logic [7:0]         dither_blue;
        logic [7:0]         dither_alpha;
        logic signed [31:0] edge_value;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [31:0] edge_number;
    } result_t;

    // One palette entry as stored
    typedef struct packed {
        logic [7:0]  mr;
        logic [7:0]  mg;
        logic [7:0]  mb;
        logic [7:0]  ma;
        logic [7:0]  dr;
        logic [7:0]  dg;
        logic [7:0]  db;
        logic [7:0]  da;
        logic [31:0] edge_code;
    } entry_t;

    // Front-to-back work item; when blend is low, the main color is final
    typedef struct packed {
        logic   blend;
        entry_t ent;
    } work_t;

    // Item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    // Top byte of the direct color codes
    localparam logic [7:0] TOP_OPAQUE    = 8'h02;
    localparam logic [7:0] TOP_TRANS     = 8'h03;
    localparam logic [7:0] TOP_DITHER    = 8'h04;
    localparam logic [7:0] TOP_TRANS_HI  = 8'h05;
    localparam logic [7:0] TOP_TRANS_LO  = 8'h06;
    localparam logic [7:0] TOP_INVISIBLE = 8'h07;

    // Fallback color and markers
    localparam logic [7:0]  ORANGE_R          = 8'd255;
    localparam logic [7:0]  ORANGE_G          = 8'd128;
    localparam logic [7:0]  ORANGE_B          = 8'd0;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'd255;
    localparam logic [31:0] EDGE_UNDEF        = 32'd255;
    localparam logic [7:0]  TRANS_ALPHA_RESET = 8'd110;

    // Entry value after the clearing pass
    localparam entry_t ENTRY_RESET = '{edge_code: EDGE_UNDEF, default: '0};

    // Register map (byte addresses)
    localparam logic [1:0] REG_TRANS_ALPHA = 2'd0;

endpackage

// ----- hw/rtl/color_code_to_rgba_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_code_to_rgba_unit: palette lookup with direct color decoding
// Input beats (push/full) either write a palette entry or look up a color
// code. Each lookup yields one result beat (empty/pop); writes yield none.
// The transparent alpha register sits at byte address 0 of the APB port.
//
// After reset the palette is cleared one entry a cycle, and full stays high
// until the clearing pass ends; then the unit takes a beat every cycle while
// the lookup stage is not stalled. A lookup passes the lookup stage, the work
// queue and the result register; a blended palette entry also passes the divider.
// Throughput: one beat a cycle for writes and direct codes while the receiver
// pops; a blended entry occupies the back end divider for a load, then two steps
// of four quotient bits, which sets the rate for runs of palette lookups.
// A two-entry work queue sits between the memory front end and the divider.
// When the receiver holds off pop, the result waits in the result register,
// the queue fills, and full rises once the lookup stage cannot drain.
// ----------------------------------------------------------------------------
module color_code_to_rgba_unit #(
    parameter int ENTRIES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cctr_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output cctr_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cctr_pkg::*;

    logic [7:0] trans_alpha_reg;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    work_t      q_wdata;
    work_t      q_rdata;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trans_alpha_reg <= TRANS_ALPHA_RESET;
        else if (psel && penable && pwrite && paddr == REG_TRANS_ALPHA)
            trans_alpha_reg <= pwdata[7:0];
    end

    assign prdata = (paddr == REG_TRANS_ALPHA) ? {24'd0, trans_alpha_reg} : 32'd0;

    // Front end: palette memory and classification
    cctr_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .trans_alpha (trans_alpha_reg),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    // Work queue
    cctr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back end: blend and result register
    cctr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ----- hw/rtl/cctr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctr_front: palette memory and code classification
// Accepts beats, writes palette entries, reads entries for lookups and
// resolves direct codes. Lookups leave as work items for the back end.
// ----------------------------------------------------------------------------
module cctr_front #(
    parameter int ENTRIES = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cctr_pkg::item_t  item,
    input  logic [7:0]       trans_alpha,
    output logic             q_push,
    output cctr_pkg::work_t  q_data,
    input  logic             q_full
);
    import cctr_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    entry_t           mem [ENTRIES];
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic             s1_valid_reg;
    logic [31:0]      s1_code_reg;
    entry_t           rd_reg;

    logic             accept;
    logic [31:0]      in_code;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic             s1_in_range;
    logic [7:0]       top;
    logic [3:0]       n5, n4, n3, n2, n1, n0;
    logic [8:0]       sum_r, sum_g, sum_b;
    logic [7:0]       r, g, b, a;
    logic             entry_defined;

    // Input handshake
    assign full     = clr_busy_reg || (s1_valid_reg && q_full);
    assign accept   = push && !full;
    assign in_code  = item.color_number;
    assign in_range = !in_code[31] && (in_code < 32'(ENTRIES));
    assign in_idx   = in_code[IDX_W-1:0];

    // Clearing pass after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(ENTRIES - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= ENTRY_RESET;
        else if (accept && item.kind == KIND_WRITE && in_range)
            mem[in_idx] <= '{mr: item.main_red,    mg: item.main_green,
                             mb: item.main_blue,   ma: item.main_alpha,
                             dr: item.dither_red,  dg: item.dither_green,
                             db: item.dither_blue, da: item.dither_alpha,
                             edge_code: item.edge_value};
        if (accept && item.kind == KIND_LOOKUP && in_range)
            rd_reg <= mem[in_idx];
    end

    // Lookup stage: holds while the queue is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept && item.kind == KIND_LOOKUP)
            s1_valid_reg <= 1'b1;
        else if (q_push)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.kind == KIND_LOOKUP)
            s1_code_reg <= in_code;
    end

    assign q_push = s1_valid_reg && !q_full;

    // Classification of the code held in the lookup stage
    assign s1_in_range = !s1_code_reg[31] && (s1_code_reg < 32'(ENTRIES));
    assign top = s1_code_reg[31:24];
    assign n5  = s1_code_reg[23:20];
    assign n4  = s1_code_reg[19:16];
    assign n3  = s1_code_reg[15:12];
    assign n2  = s1_code_reg[11:8];
    assign n1  = s1_code_reg[7:4];
    assign n0  = s1_code_reg[3:0];

    // nibble * 17 is the nibble repeated
    assign sum_r = {1'b0, n5, n5} + {1'b0, n2, n2};
    assign sum_g = {1'b0, n4, n4} + {1'b0, n1, n1};
    assign sum_b = {1'b0, n3, n3} + {1'b0, n0, n0};

    assign entry_defined = ({rd_reg.mr, rd_reg.mg, rd_reg.mb, rd_reg.ma} != '0)
                        || (rd_reg.edge_code != EDGE_UNDEF);

    always_comb
    begin
        r = ORANGE_R;
        g = ORANGE_G;
        b = ORANGE_B;
        a = ALPHA_OPAQUE;
        q_data = '0;
        if (s1_in_range)
        begin
            // palette entry; an untouched entry falls back to orange
            q_data.ent   = rd_reg;
            q_data.blend = entry_defined;
            if (!entry_defined)
            begin
                q_data.ent.mr = ORANGE_R;
                q_data.ent.mg = ORANGE_G;
                q_data.ent.mb = ORANGE_B;
                q_data.ent.ma = ALPHA_OPAQUE;
            end
        end
        else
        begin
            if (!s1_code_reg[31])
            begin
                unique case (top)
                    TOP_OPAQUE, TOP_TRANS:
                    begin
                        r = s1_code_reg[23:16];
                        g = s1_code_reg[15:8];
                        b = s1_code_reg[7:0];
                        if (top == TOP_TRANS)
                            a = trans_alpha;
                    end
                    TOP_DITHER:
                    begin
                        r = sum_r[8:1];
                        g = sum_g[8:1];
                        b = sum_b[8:1];
                    end
                    TOP_TRANS_HI:
                    begin
                        r = {n5, n5};
                        g = {n4, n4};
                        b = {n3, n3};
                        a = trans_alpha;
                    end
                    TOP_TRANS_LO:
                    begin
                        r = {n2, n2};
                        g = {n1, n1};
                        b = {n0, n0};
                        a = trans_alpha;
                    end
                    TOP_INVISIBLE:
                    begin
                        r = '0;
                        g = '0;
                        b = '0;
                        a = '0;
                    end
                    default: ;
                endcase
                // fully transparent direct colors carry no color
                if (a == '0)
                begin
                    r = '0;
                    g = '0;
                    b = '0;
                end
            end
            q_data.blend         = 1'b0;
            q_data.ent.mr        = r;
            q_data.ent.mg        = g;
            q_data.ent.mb        = b;
            q_data.ent.ma        = a;
            q_data.ent.edge_code = '0;
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> full)
        else $error("input open during clearing pass");

    a_stall_holds_code: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && q_full) |=> (s1_valid_reg && $stable(s1_code_reg)))
        else $error("stalled lookup lost its code");

    a_lookup_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == KIND_LOOKUP) |=> s1_valid_reg)
        else $error("accepted lookup did not reach the lookup stage");

    a_no_push_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !clr_busy_reg)
        else $error("work item issued during clearing pass");
`endif

endmodule

// ----- hw/rtl/cctr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctr_queue: two-entry work queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module cctr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cctr_pkg::work_t  wdata,
    output logic             full,
    input  logic             pop,
    output cctr_pkg::work_t  rdata,
    output logic             empty
);
    import cctr_pkg::*;

    work_t      slot [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = slot[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 2'd1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 2'd1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot[wr_ptr_reg] <= wdata;
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("work queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("work queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("work queue count out of range");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !full) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("work queue count did not follow a push");
`endif

endmodule

// ----- hw/rtl/cctr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctr_back: alpha-weighted blend and result register
// Resolved colors pass straight to the result register. Palette entries are
// blended per component: (cm*am + cd*ad) / (am + ad) by a restoring divider
// that retires four quotient bits a cycle in each of three lanes if unstalled.
// ----------------------------------------------------------------------------
module cctr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cctr_pkg::work_t   q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output cctr_pkg::result_t result
);
    import cctr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic        half_reg, half_next;
    logic [8:0]  den_reg;
    logic        den_zero_reg;
    logic [7:0]  alpha_reg;
    logic [31:0] edge_reg;
    logic [16:0] work_reg [3];
    logic        out_valid_reg;
    result_t     result_reg;

    logic [2:0][7:0] main_c;
    logic [2:0][7:0] dith_c;
    logic [16:0] num [3];
    logic [16:0] step_w [3];
    logic [8:0]  den_in;
    logic        slot_free;
    logic        load;
    logic        step;
    logic        out_load;
    result_t     out_data;

    // Four restoring division steps; w holds {remainder, numerator/quotient}
    function automatic logic [16:0] div_step4(input logic [16:0] w,
                                              input logic [8:0]  den);
        logic [9:0]  t;
        logic [16:0] v;
        v = w;
        for (int i = 0; i < 4; i++)
        begin
            t = {v[16:8], v[7]};
            if (t >= {1'b0, den})
                v = {9'(t - {1'b0, den}), v[6:0], 1'b1};
            else
                v = {t[8:0], v[6:0], 1'b0};
        end
        return v;
    endfunction

    // Weighted numerators of the three lanes (lane 2 red, 1 green, 0 blue)
    assign main_c = {q_data.ent.mr, q_data.ent.mg, q_data.ent.mb};
    assign dith_c = {q_data.ent.dr, q_data.ent.dg, q_data.ent.db};
    assign den_in = {1'b0, q_data.ent.ma} + {1'b0, q_data.ent.da};

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l]    = 17'(main_c[l] * q_data.ent.ma) + 17'(dith_c[l] * q_data.ent.da);
            step_w[l] = div_step4(work_reg[l], den_reg);
        end
    end

    assign slot_free = !out_valid_reg || pop;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        step       = 1'b0;
        out_load   = 1'b0;
        out_data   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.blend)
                    begin
                        q_pop      = 1'b1;
                        load       = 1'b1;
                        half_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                    else if (slot_free)
                    begin
                        q_pop                = 1'b1;
                        out_load             = 1'b1;
                        out_data.red         = q_data.ent.mr;
                        out_data.green       = q_data.ent.mg;
                        out_data.blue        = q_data.ent.mb;
                        out_data.alpha       = q_data.ent.ma;
                        out_data.edge_number = q_data.ent.edge_code;
                    end
                end
            end
            ST_DIV:
            begin
                if (!half_reg)
                begin
                    step      = 1'b1;
                    half_next = 1'b1;
                end
                else if (slot_free)
                begin
                    // last four quotient bits go straight to the result
                    out_load             = 1'b1;
                    out_data.red         = den_zero_reg ? 8'd0 : step_w[2][7:0];
                    out_data.green       = den_zero_reg ? 8'd0 : step_w[1][7:0];
                    out_data.blue        = den_zero_reg ? 8'd0 : step_w[0][7:0];
                    out_data.alpha       = alpha_reg;
                    out_data.edge_number = edge_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            den_reg      <= den_in;
            den_zero_reg <= (den_in == '0);
            alpha_reg    <= den_in[8:1];
            edge_reg     <= q_data.ent.edge_code;
            for (int l = 0; l < 3; l++)
                work_reg[l] <= num[l];
        end
        else if (step)
        begin
            for (int l = 0; l < 3; l++)
                work_reg[l] <= step_w[l];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= out_data;
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !q_pop)
        else $error("work item taken while divider busy");

    a_first_half_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !half_reg) |=> (state_reg == ST_DIV && half_reg))
        else $error("divider skipped its second half");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result overwritten before it was taken");

    a_pop_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("work taken from an empty queue");
`endif

endmodule
